// ===== src/ncofs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncofs_pkg
// Shared widths, defaults and the quarter-wave sine table generator for the
// nco complex frequency shifter.
// ----------------------------------------------------------------------------
package ncofs_pkg;

	// fixed field widths
	localparam int IQ_W   = 16;
	localparam int OUT_W  = 17;
	localparam int STEP_W = 32;

	// default sizing
	localparam int PHASE_BITS_DEF      = 32;
	localparam int TABLE_ADDR_BITS_DEF = 10;
	localparam int SINE_BITS_DEF       = 16;

	// pi/2 in q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// unsigned quotient by shift and subtract, only used while building the table
	function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 64'd0;
		rem = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// sin(x) for 0 <= x < pi/2, argument and result in q30 (taylor series)
	function automatic longint unsigned sin_q30(longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned dvsr;
		longint          sum;
		int              k;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (k = 1; k < 16; k++) begin
			if (term != 64'd0) begin
				dvsr = longint'(unsigned'((2 * k) * (2 * k + 1)));
				term = (term * x2) >> 30;
				term = udiv64(term, dvsr);
				if (k % 2 == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
		end
		if (sum < 0)
			sum = 0;
		return longint'(unsigned'(sum));
	endfunction

	// table entry n: sine at the middle of bin n, amplitude 2^(sine_bits-1)-1
	function automatic longint unsigned sine_entry(int n, int addr_bits, int sine_bits);
		longint unsigned x;
		longint unsigned s;
		longint unsigned amp;
		x   = (HALF_PI_Q30 * (64'd2 * longint'(unsigned'(n)) + 64'd1)) >> (addr_bits + 1);
		s   = sin_q30(x);
		amp = (64'd1 << (sine_bits - 1)) - 64'd1;
		return (s * amp + (64'd1 << 29)) >> 30;
	endfunction

endpackage
`default_nettype wire

// ===== src/ncofs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ncofs_if
// Valid/ready stream interfaces for the input samples and the shifted
// results of the nco complex frequency shifter.
// ----------------------------------------------------------------------------

// raw i/q sample stream
interface ncofs_in_if import ncofs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [IQ_W-1:0] in_i;
	logic signed [IQ_W-1:0] in_q;

	modport source (output valid, output in_i, output in_q, input ready);
	modport sink   (input valid, input in_i, input in_q, output ready);
endinterface

// shifted i/q result stream
interface ncofs_out_if import ncofs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] out_i;
	logic signed [OUT_W-1:0] out_q;

	modport source (output valid, output out_i, output out_q, input ready);
	modport sink   (input valid, input out_i, input out_q, output ready);
endinterface
`default_nettype wire

// ===== src/nco_complex_frequency_shifter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nco_complex_frequency_shifter
// Rotates each i/q sample by a running nco phase, shifting the spectrum by
// phase_step / 2^32 of the sample rate.
// ----------------------------------------------------------------------------
// One sample is taken every clock while the stream is not stalled; a result
// passes through three registered stages (phase add with sine table read,
// four multiplies, sum and rounding), and the stream stalls only when the
// output side holds off with all three stages full. The phase accumulator
// steps once per accepted transaction, so the first sample after reset
// already uses one step. Both sin and cos come from one quarter-wave table
// read at two addresses, and the outputs are q15 with rounding half up. The
// user writes phase_step only while the block is empty; the block does not enforce it.
module nco_complex_frequency_shifter import ncofs_pkg::*; #(
	parameter int PHASE_BITS      = PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
	parameter int SINE_BITS       = SINE_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     phase_step_we,
	input  wire        [STEP_W-1:0] phase_step,
	ncofs_in_if.sink                iq_in,
	ncofs_out_if.source             iq_out
);

	localparam int ROM_DEPTH = 1 << TABLE_ADDR_BITS;
	localparam int STEP_UP   = (PHASE_BITS >= STEP_W) ? PHASE_BITS - STEP_W : 0;
	localparam int STEP_DN   = (PHASE_BITS >= STEP_W) ? 0 : STEP_W - PHASE_BITS;
	localparam int EXT_W     = PHASE_BITS + STEP_W;
	localparam int PROD_W    = SINE_BITS + IQ_W;
	localparam int SUM_W     = PROD_W + 1;

	typedef logic [SINE_BITS-1:0] rom_t [ROM_DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		for (int n = 0; n < ROM_DEPTH; n++)
			r[n] = SINE_BITS'(sine_entry(n, TABLE_ADDR_BITS, SINE_BITS));
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// configuration and phase state
	logic signed [STEP_W-1:0]     phase_step_q;
	logic        [PHASE_BITS-1:0] phase_acc_q;
	logic signed [EXT_W-1:0]      step_ext;
	logic signed [EXT_W-1:0]      step_algn;
	logic        [PHASE_BITS-1:0] phase_inc;
	logic        [PHASE_BITS-1:0] phase_nxt;

	// table lookup
	logic [TABLE_ADDR_BITS+1:0] tbl_idx;
	logic [1:0]                 quad;
	logic [TABLE_ADDR_BITS-1:0] tbl_addr;
	logic [TABLE_ADDR_BITS-1:0] sin_addr;
	logic [TABLE_ADDR_BITS-1:0] cos_addr;

	// pipeline control
	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic in_xact;

	// stage 1: table magnitudes, signs, sample
	logic        [SINE_BITS-1:0] sin_mag_s1;
	logic        [SINE_BITS-1:0] cos_mag_s1;
	logic                        sin_neg_s1;
	logic                        cos_neg_s1;
	logic signed [IQ_W-1:0]      i_s1;
	logic signed [IQ_W-1:0]      q_s1;
	logic signed [SINE_BITS-1:0] sin_val;
	logic signed [SINE_BITS-1:0] cos_val;

	// stage 2: products
	logic signed [PROD_W-1:0] ci_s2, sq_s2, si_s2, cq_s2;
	logic signed [SUM_W-1:0]  sum_i, sum_q;

	// stage 3: result register
	logic signed [OUT_W-1:0] out_i_s3;
	logic signed [OUT_W-1:0] out_q_s3;

	// handshake chain, a stage takes new data when it is empty or drains
	assign rdy_s3      = !vld_s3 || iq_out.ready;
	assign rdy_s2      = !vld_s2 || rdy_s3;
	assign rdy_s1      = !vld_s1 || rdy_s2;
	assign iq_in.ready = rdy_s1;
	assign in_xact     = iq_in.valid && rdy_s1;

	// step aligned to the accumulator width
	assign step_ext  = EXT_W'(phase_step_q);
	assign step_algn = (step_ext <<< STEP_UP) >>> STEP_DN;
	assign phase_inc = step_algn[PHASE_BITS-1:0];
	assign phase_nxt = phase_acc_q + phase_inc;

	// quadrant folding of the updated phase
	assign tbl_idx  = phase_nxt[PHASE_BITS-1 -: TABLE_ADDR_BITS+2];
	assign quad     = tbl_idx[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
	assign tbl_addr = tbl_idx[TABLE_ADDR_BITS-1:0];
	assign sin_addr = quad[0] ? ~tbl_addr : tbl_addr;
	assign cos_addr = quad[0] ? tbl_addr : ~tbl_addr;

	// config register and phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			phase_acc_q  <= '0;
		end else begin
			if (phase_step_we)
				phase_step_q <= phase_step;
			if (in_xact)
				phase_acc_q <= phase_nxt;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1)
				vld_s1 <= iq_in.valid;
			if (rdy_s2)
				vld_s2 <= vld_s1;
			if (rdy_s3)
				vld_s3 <= vld_s2;
		end
	end

	// stage 1: dual read of the sine table
	always_ff @(posedge clk) begin
		if (in_xact) begin
			sin_mag_s1 <= SINE_ROM[sin_addr];
			cos_mag_s1 <= SINE_ROM[cos_addr];
			sin_neg_s1 <= quad[1];
			cos_neg_s1 <= quad[1] ^ quad[0];
			i_s1       <= iq_in.in_i;
			q_s1       <= iq_in.in_q;
		end
	end

	// signed sin and cos
	assign sin_val = sin_neg_s1 ? -$signed(sin_mag_s1) : $signed(sin_mag_s1);
	assign cos_val = cos_neg_s1 ? -$signed(cos_mag_s1) : $signed(cos_mag_s1);

	// stage 2: complex multiply partial products
	always_ff @(posedge clk) begin
		if (vld_s1 && rdy_s2) begin
			ci_s2 <= PROD_W'(cos_val) * PROD_W'(i_s1);
			sq_s2 <= PROD_W'(sin_val) * PROD_W'(q_s1);
			si_s2 <= PROD_W'(sin_val) * PROD_W'(i_s1);
			cq_s2 <= PROD_W'(cos_val) * PROD_W'(q_s1);
		end
	end

	// combine and round half up
	assign sum_i = SUM_W'(ci_s2) - SUM_W'(sq_s2) + (SUM_W'(1) <<< (SINE_BITS - 2));
	assign sum_q = SUM_W'(si_s2) + SUM_W'(cq_s2) + (SUM_W'(1) <<< (SINE_BITS - 2));

	// stage 3: result register
	always_ff @(posedge clk) begin
		if (vld_s2 && rdy_s3) begin
			out_i_s3 <= sum_i[SINE_BITS-1 +: OUT_W];
			out_q_s3 <= sum_q[SINE_BITS-1 +: OUT_W];
		end
	end

	assign iq_out.valid = vld_s3;
	assign iq_out.out_i = out_i_s3;
	assign iq_out.out_q = out_q_s3;

	// phase moves only with an input transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_xact |=> $stable(phase_acc_q))
		else $error("phase accumulator moved without an input transaction");

	// an accepted sample always lands in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> vld_s1)
		else $error("accepted sample lost at stage 1");

	// stage 2 drains into an empty result register
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !vld_s3) |=> vld_s3)
		else $error("stage 2 data not moved into the result register");

endmodule
`default_nettype wire
